### sv/q4sd_pkg.sv
// Types, constants and widths shared by the 4-QAM soft-bit demapper modules.
package q4sd_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned LLR_BITS    = 24;

  localparam int unsigned PT_W       = 16;
  localparam int unsigned NS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_PTS    = 4;

  localparam int unsigned MAG_W     = (SAMPLE_BITS > PT_W) ? SAMPLE_BITS : PT_W;
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned D2_W      = SQ_W + 1;
  localparam int unsigned D2_SHIFT  = 12;
  localparam int unsigned D12_W     = D2_W - D2_SHIFT;
  localparam int unsigned PROD_W    = D12_W + NS_W;
  localparam int unsigned NS_SHIFT  = 8;
  localparam int unsigned MET_MAG_W = PROD_W - NS_SHIFT;
  localparam int unsigned MET_W     = MET_MAG_W + 1;
  localparam int unsigned L_W       = MET_W + 1;
  localparam int unsigned DIFF_W    = L_W + 1;
  localparam int unsigned CORR_W    = 12;

  localparam int unsigned D2_RND  = 2048;
  localparam int unsigned MET_RND = 128;

  localparam int unsigned CORR_KNEE = 8192;
  localparam int unsigned CORR_END  = 17751;
  localparam int unsigned CORR_B0   = 2839;
  localparam int unsigned CORR_S0   = 18554;
  localparam int unsigned CORR_B1   = 965;
  localparam int unsigned CORR_S1   = 3564;
  localparam int unsigned CORR_RND  = 32768;

  localparam int unsigned META_DEPTH = 8;
  localparam int unsigned OUT_DEPTH  = 4;

  localparam logic [CFG_DATA_W-1:0] POINT0_RESET = 32'h0B50_0B50;
  localparam logic [CFG_DATA_W-1:0] POINT1_RESET = 32'h0B50_F4B0;
  localparam logic [CFG_DATA_W-1:0] POINT2_RESET = 32'hF4B0_0B50;
  localparam logic [CFG_DATA_W-1:0] POINT3_RESET = 32'hF4B0_F4B0;
  localparam logic [NS_W-1:0]       NOISE_SCALE_RESET = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT0      = 3'd0,
    REG_POINT1      = 3'd1,
    REG_POINT2      = 3'd2,
    REG_POINT3      = 3'd3,
    REG_NOISE_SCALE = 3'd4
  } cfg_reg_t;

  typedef logic signed [MET_W-1:0] metric_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic                          only_first_bit;
    logic                          end_of_block;
  } sym_t;

  typedef struct packed {
    logic signed [LLR_BITS-1:0] llr;
    logic                       bit_position;
    logic                       last_of_symbol;
    logic                       block_end;
  } res_t;

  typedef struct packed {
    metric_t [NUM_PTS-1:0] m;
    logic                  only_first_bit;
    logic                  end_of_block;
  } meta_t;

endpackage

### sv/q4sd_fifo.sv
// Small register FIFO with fill level, used between and after the demapper stages.
module q4sd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             rd,
  output logic [WIDTH-1:0]                 rdata,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       level
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + AW'(1);
      end
      unique case ({wr, rd})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign rdata = mem[rptr];
  assign empty = (level == '0);

endmodule

### sv/q4sd_front.sv
// Front end: configuration registers, symbol intake and point-metric pipeline.
module q4sd_front #(
  parameter int unsigned META_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  q4sd_pkg::sym_t                      sym,
  input  logic                                cfg_we,
  input  logic [q4sd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [q4sd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [$clog2(META_DEPTH+1)-1:0]     q_level,
  output logic                                q_wr,
  output q4sd_pkg::meta_t                     q_wdata
);
  import q4sd_pkg::*;

  localparam int unsigned LVL_W  = $clog2(META_DEPTH+1);
  localparam int unsigned STAGES = 4;
  localparam int unsigned TOT_W  = LVL_W + $clog2(STAGES+1);

  logic [CFG_DATA_W-1:0] pt [NUM_PTS];
  logic [NS_W-1:0]       noise_scale;

  logic [STAGES-1:0] v;
  logic              one_s [STAGES];
  logic              eob_s [STAGES];

  logic [MAG_W-1:0]  mag_i [NUM_PTS];
  logic [MAG_W-1:0]  mag_q [NUM_PTS];
  logic [SQ_W-1:0]   sq_i  [NUM_PTS];
  logic [SQ_W-1:0]   sq_q  [NUM_PTS];
  logic [D12_W-1:0]  d12   [NUM_PTS];
  logic [PROD_W-1:0] prod  [NUM_PTS];

  logic signed [MAG_W:0] diff_i [NUM_PTS];
  logic signed [MAG_W:0] diff_q [NUM_PTS];
  logic [D2_W-1:0]       d2_rnd [NUM_PTS];
  logic [PROD_W-1:0]     m_rnd  [NUM_PTS];
  logic [TOT_W-1:0]      total;
  logic                  accept;

  assign accept = push && !full;
  assign total  = TOT_W'(q_level) + TOT_W'($countones(v));
  assign full   = (total >= TOT_W'(META_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pt[0]       <= POINT0_RESET;
      pt[1]       <= POINT1_RESET;
      pt[2]       <= POINT2_RESET;
      pt[3]       <= POINT3_RESET;
      noise_scale <= NOISE_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT0:      pt[0] <= cfg_data;
        REG_POINT1:      pt[1] <= cfg_data;
        REG_POINT2:      pt[2] <= cfg_data;
        REG_POINT3:      pt[3] <= cfg_data;
        REG_NOISE_SCALE: noise_scale <= cfg_data[NS_W-1:0];
        default:         noise_scale <= noise_scale;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[STAGES-2:0], accept};
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PTS; k++) begin
      diff_i[k] = (MAG_W+1)'($signed(pt[k][PT_W-1:0])) - (MAG_W+1)'(sym.sample_i);
      diff_q[k] = (MAG_W+1)'($signed(pt[k][2*PT_W-1:PT_W])) - (MAG_W+1)'(sym.sample_q);
      d2_rnd[k] = D2_W'(sq_i[k]) + D2_W'(sq_q[k]) + D2_W'(D2_RND);
      m_rnd[k]  = prod[k] + PROD_W'(MET_RND);
    end
  end

  always_ff @(posedge clk) begin
    one_s[0] <= sym.only_first_bit;
    eob_s[0] <= sym.end_of_block;
    for (int s = 1; s < STAGES; s++) begin
      one_s[s] <= one_s[s-1];
      eob_s[s] <= eob_s[s-1];
    end
    for (int k = 0; k < NUM_PTS; k++) begin
      mag_i[k] <= diff_i[k][MAG_W] ? MAG_W'(-diff_i[k]) : diff_i[k][MAG_W-1:0];
      mag_q[k] <= diff_q[k][MAG_W] ? MAG_W'(-diff_q[k]) : diff_q[k][MAG_W-1:0];
      sq_i[k]  <= SQ_W'(mag_i[k]) * SQ_W'(mag_i[k]);
      sq_q[k]  <= SQ_W'(mag_q[k]) * SQ_W'(mag_q[k]);
      d12[k]   <= d2_rnd[k][D2_W-1:D2_SHIFT];
      prod[k]  <= PROD_W'(d12[k]) * PROD_W'(noise_scale);
    end
  end

  always_comb begin
    q_wr                   = v[STAGES-1];
    q_wdata.only_first_bit = one_s[STAGES-1];
    q_wdata.end_of_block   = eob_s[STAGES-1];
    for (int k = 0; k < NUM_PTS; k++) begin
      q_wdata.m[k] = -$signed({1'b0, m_rnd[k][PROD_W-1:NS_SHIFT]});
    end
  end

endmodule

### sv/q4sd_back.sv
// Back end: per-bit max-star combination, LLR difference and saturation.
module q4sd_back #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  q4sd_pkg::meta_t                    q_head,
  output logic                               q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
  output logic                               out_wr,
  output q4sd_pkg::res_t                     out_wdata
);
  import q4sd_pkg::*;

  localparam int unsigned LVL_W = $clog2(OUT_DEPTH+1);
  localparam int unsigned TOT_W = LVL_W + 2;
  localparam int unsigned SAT_W = (DIFF_W > LLR_BITS) ? DIFF_W : LLR_BITS;
  localparam logic signed [SAT_W-1:0] LLR_HI =
    SAT_W'((64'sd1 <<< (LLR_BITS-1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] LLR_LO = -LLR_HI - SAT_W'(1);

  function automatic logic [CORR_W-1:0] corr_term(input logic [MET_MAG_W-1:0] x);
    logic        near;
    logic        far;
    logic [14:0] coef;
    logic [29:0] p;
    logic [29:0] r;
    logic [CORR_W-1:0] base;
    begin
      near = (x < MET_MAG_W'(CORR_KNEE));
      far  = (x >= MET_MAG_W'(CORR_END));
      coef = near ? 15'(CORR_S0) : 15'(CORR_S1);
      base = near ? CORR_W'(CORR_B0) : CORR_W'(CORR_B1);
      p    = 30'(coef) * 30'(x[14:0]);
      r    = p + 30'(CORR_RND);
      return far ? '0 : base - CORR_W'(r[29:16]);
    end
  endfunction

  logic             bit_sel;
  logic             issue;
  logic             last;
  logic [TOT_W-1:0] total;

  metric_t               a [2];
  metric_t               b [2];
  metric_t               b1_mx [2];
  logic [MET_MAG_W-1:0]  b1_d  [2];
  logic                  b1_v;
  logic                  b1_pos;
  logic                  b1_last;
  logic                  b1_eob;

  logic signed [L_W-1:0] b2_l [2];
  logic                  b2_v;
  logic                  b2_pos;
  logic                  b2_last;
  logic                  b2_eob;

  logic signed [DIFF_W-1:0] diff;
  logic signed [SAT_W-1:0]  dx;

  assign total = TOT_W'(out_level) + TOT_W'(b1_v) + TOT_W'(b2_v);
  assign issue = !q_empty && (total < TOT_W'(OUT_DEPTH));
  assign last  = bit_sel || q_head.only_first_bit;
  assign q_pop = issue && last;

  always_comb begin
    a[0] = q_head.m[0];
    b[0] = bit_sel ? q_head.m[1] : q_head.m[2];
    a[1] = bit_sel ? q_head.m[2] : q_head.m[1];
    b[1] = q_head.m[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_sel <= 1'b0;
      b1_v    <= 1'b0;
      b2_v    <= 1'b0;
    end else begin
      if (issue) begin
        bit_sel <= !last;
      end
      b1_v <= issue;
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    b1_pos  <= bit_sel;
    b1_last <= last;
    b1_eob  <= last && q_head.end_of_block;
    for (int j = 0; j < 2; j++) begin
      b1_mx[j] <= (a[j] > b[j]) ? a[j] : b[j];
      b1_d[j]  <= (a[j] > b[j]) ? MET_MAG_W'(a[j] - b[j]) : MET_MAG_W'(b[j] - a[j]);
    end
    b2_pos  <= b1_pos;
    b2_last <= b1_last;
    b2_eob  <= b1_eob;
    for (int j = 0; j < 2; j++) begin
      b2_l[j] <= L_W'(b1_mx[j]) + L_W'($signed({1'b0, corr_term(b1_d[j])}));
    end
  end

  always_comb begin
    diff   = DIFF_W'(b2_l[1]) - DIFF_W'(b2_l[0]);
    dx     = SAT_W'(diff);
    out_wr = b2_v;
    priority if (dx > LLR_HI) begin
      out_wdata.llr = LLR_HI[LLR_BITS-1:0];
    end else if (dx < LLR_LO) begin
      out_wdata.llr = LLR_LO[LLR_BITS-1:0];
    end else begin
      out_wdata.llr = dx[LLR_BITS-1:0];
    end
    out_wdata.bit_position   = b2_pos;
    out_wdata.last_of_symbol = b2_last;
    out_wdata.block_end      = b2_eob;
  end

endmodule

### sv/qam4_soft_bit_demapper.sv
// Top level of the 4-QAM soft-bit demapper: front end, metric queue, back end, result queue.
//
//   beat      direction  handshake                  payload
//   symbol    in         push / full                sym  (sample_i, sample_q, flags)
//   result    out        empty / pop                res  (llr, bit_position, tags)
//   config    in         cfg_we, cfg_index          cfg_data
//
// Sustained rate: a symbol with both bits gives two LLRs, one with only_first_bit gives one;
// the back end issues one LLR per cycle through its max-star pairs while the metric queue
// holds a symbol and the result queue has room.
// The front end takes a burst of up to META_DEPTH symbols while the back end stalls.
// rst clears queues and pipeline valids and loads the default constellation and scale.
// A stalled result holds on res; new symbols are accepted meanwhile until the queues fill.
module qam4_soft_bit_demapper #(
  parameter int unsigned META_DEPTH = q4sd_pkg::META_DEPTH,
  parameter int unsigned OUT_DEPTH  = q4sd_pkg::OUT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  q4sd_pkg::sym_t                   sym,
  output logic                             empty,
  input  logic                             pop,
  output q4sd_pkg::res_t                   res,
  input  logic                             cfg_we,
  input  logic [q4sd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [q4sd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import q4sd_pkg::*;

  logic                              q_wr;
  meta_t                             q_wdata;
  meta_t                             q_head;
  logic                              q_pop;
  logic                              q_empty;
  logic [$clog2(META_DEPTH+1)-1:0]   q_level;

  logic                              out_wr;
  res_t                              out_wdata;
  logic [$clog2(OUT_DEPTH+1)-1:0]    out_level;
  logic                              out_rd;

  assign out_rd = pop && !empty;

  q4sd_front #(
    .META_DEPTH (META_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sym       (sym),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  q4sd_fifo #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (META_DEPTH)
  ) u_meta_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_head),
    .empty (q_empty),
    .level (q_level)
  );

  q4sd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_level (out_level),
    .out_wr    (out_wr),
    .out_wdata (out_wdata)
  );

  q4sd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_wr),
    .wdata (out_wdata),
    .rd    (out_rd),
    .rdata (res),
    .empty (empty),
    .level (out_level)
  );

endmodule

### sv/q4sd_checker.sv
// Port-level checks for the 4-QAM soft-bit demapper, bound to the top level.
module q4sd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input q4sd_pkg::res_t                   res
);
  import q4sd_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_mid_symbol_is_bit0: assert property (@(posedge clk) disable iff (rst)
    !empty && !res.last_of_symbol |-> !res.bit_position && !res.block_end)
    else $error("non-final beat of a symbol is not a plain bit 0 beat");

  a_bit1_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && res.bit_position |-> res.last_of_symbol)
    else $error("bit 1 beat not marked last of symbol");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(res))
    else $error("stalled result beat changed");

endmodule

bind qam4_soft_bit_demapper q4sd_checker u_checker (.*);
